// ===== rtl/kmfs_pkg.sv =====
// Package for the keyboard mode flag stack: payload structs, action and
// set-mode codes, and default sizes. No dependencies.
package kmfs_pkg;

  localparam int unsigned KMFS_STACK_DEPTH = 8;
  localparam int unsigned FLAG_W           = 5;
  localparam int unsigned COUNT_W          = 8;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_SET   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_KEEP    = 2'd0,
    MODE_REPLACE = 2'd1,
    MODE_OR      = 2'd2,
    MODE_ANDNOT  = 2'd3
  } set_mode_t;

  typedef struct packed {
    action_t             action;
    logic                screen;
    logic [FLAG_W-1:0]   flag_word;
    logic [COUNT_W-1:0]  pop_count;
    set_mode_t           set_mode;
  } in_word_t;

  typedef struct packed {
    logic              out_screen;
    logic [FLAG_W-1:0] published_flags;
  } out_word_t;

endpackage

// ===== rtl/kmfs_mem.sv =====
// Flag entry memory: one write port, one read port with registered data.
// Depends on nothing; sized by the top level.
module kmfs_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 5
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/keyboard_mode_flag_stack.sv =====
// Keyboard mode flag stack, top level: two bounded flag stacks kept as ring
// buffers in kmfs_mem. Uses kmfs_pkg.
// Result strobe registered in s1_valid_r then out_valid_r; one word per cycle.
// The pop result comes from the registered read port of the entry memory.
// Reset (rst_n low, synchronous) empties both stacks and holds busy high;
// entry contents are not cleared. The receiver cannot stall out_valid.
module keyboard_mode_flag_stack import kmfs_pkg::*; #(
  parameter int unsigned STACK_DEPTH = KMFS_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_valid,
  output out_word_t out_data
);

  localparam int unsigned PW  = $clog2(STACK_DEPTH);
  localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(2 * STACK_DEPTH);
  localparam int unsigned CW  = (DW > COUNT_W) ? DW : COUNT_W;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] a, logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PW+1)'(STACK_DEPTH)) s = s - (PW+1)'(STACK_DEPTH);
    return s[PW-1:0];
  endfunction

  logic [DW-1:0]     depth_r [2];
  logic [DW-1:0]     depth_nxt [2];
  logic [PW-1:0]     base_r [2];
  logic [PW-1:0]     base_nxt [2];
  logic [FLAG_W-1:0] top_r [2];
  logic [FLAG_W-1:0] top_nxt [2];
  logic [FLAG_W-1:0] top_eff [2];

  logic              s1_valid_r, s1_scr_r, s1_pop_r, s1_nonempty_r;
  logic [FLAG_W-1:0] s1_val_r;
  logic [FLAG_W-1:0] s1_pub;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic              acc;
  logic              scr;
  logic [DW-1:0]     depth, nd;
  logic [PW-1:0]     base, nb, wr_ptr, rd_ptr;
  logic [FLAG_W-1:0] cur_top, new_top, t;
  logic              is_pop, wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [FLAG_W-1:0] rd_data;

  assign busy = ~rst_n;
  assign acc  = start && !busy;
  assign scr  = in_data.screen;

  assign s1_pub = s1_pop_r ? (s1_nonempty_r ? rd_data : '0) : s1_val_r;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      top_eff[s] = (s1_valid_r && s1_pop_r && (s1_scr_r == 1'(s))) ? s1_pub : top_r[s];
    end
  end

  assign depth   = depth_r[scr];
  assign base    = base_r[scr];
  assign cur_top = top_eff[scr];

  always_comb begin
    nd      = depth;
    nb      = base;
    wr_ptr  = base;
    rd_ptr  = wrap_add(base, PW'(nd - DW'(1)));
    new_top = cur_top;
    is_pop  = 1'b0;
    wr_en   = 1'b0;
    t       = '0;
    unique case (in_data.action)
      ACT_PUSH: begin
        wr_en   = 1'b1;
        new_top = in_data.flag_word;
        if (depth == DW'(STACK_DEPTH)) begin
          wr_ptr = base;
          nb     = wrap_add(base, PW'(1));
        end else begin
          wr_ptr = wrap_add(base, PW'(depth));
          nd     = depth + DW'(1);
        end
      end
      ACT_POP: begin
        is_pop = 1'b1;
        if (CW'(in_data.pop_count) > CW'(depth)) nd = '0;
        else nd = depth - DW'(in_data.pop_count);
        rd_ptr = wrap_add(base, PW'(nd - DW'(1)));
      end
      ACT_SET: begin
        wr_en = 1'b1;
        if (depth == '0) begin
          t      = '0;
          nd     = DW'(1);
          wr_ptr = base;
        end else begin
          t      = cur_top;
          wr_ptr = wrap_add(base, PW'(depth - DW'(1)));
        end
        unique case (in_data.set_mode)
          MODE_REPLACE: t = in_data.flag_word;
          MODE_OR:      t = t | in_data.flag_word;
          MODE_ANDNOT:  t = t & ~in_data.flag_word;
          default:      t = t;
        endcase
        new_top = t;
      end
      default: begin
        nd      = '0;
        new_top = '0;
      end
    endcase
  end

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      depth_nxt[s] = depth_r[s];
      base_nxt[s]  = base_r[s];
      top_nxt[s]   = top_eff[s];
      if (acc && (scr == 1'(s))) begin
        depth_nxt[s] = nd;
        base_nxt[s]  = nb;
        if (!is_pop) top_nxt[s] = new_top;
      end
    end
  end

  assign wr_addr = scr ? AW'(wr_ptr) + AW'(STACK_DEPTH) : AW'(wr_ptr);
  assign rd_addr = scr ? AW'(rd_ptr) + AW'(STACK_DEPTH) : AW'(rd_ptr);

  kmfs_mem #(
    .DEPTH(2 * STACK_DEPTH),
    .WIDTH(FLAG_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (acc && wr_en),
    .wr_addr(wr_addr),
    .wr_data(new_top),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r[0]  <= '0;
      depth_r[1]  <= '0;
      base_r[0]   <= '0;
      base_r[1]   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r[0]  <= depth_nxt[0];
      depth_r[1]  <= depth_nxt[1];
      base_r[0]   <= base_nxt[0];
      base_r[1]   <= base_nxt[1];
      s1_valid_r  <= acc;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    top_r[0]      <= top_nxt[0];
    top_r[1]      <= top_nxt[1];
    s1_scr_r      <= scr;
    s1_pop_r      <= is_pop;
    s1_nonempty_r <= (nd != '0);
    s1_val_r      <= new_top;
    out_data_r    <= '{out_screen: s1_scr_r, published_flags: s1_pub};
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##2 out_valid)
    else $error("accepted word produced no result");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r[0] <= DW'(STACK_DEPTH)) && (depth_r[1] <= DW'(STACK_DEPTH)))
    else $error("stack depth beyond limit");

  a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (base_r[0] < PW'(STACK_DEPTH - 1) || base_r[0] == PW'(STACK_DEPTH - 1)) &&
    (base_r[1] < PW'(STACK_DEPTH - 1) || base_r[1] == PW'(STACK_DEPTH - 1)))
    else $error("ring base out of range");

  a_push_publishes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.action == ACT_PUSH) |->
      ##2 (out_data.published_flags == $past(in_data.flag_word, 2)))
    else $error("push did not publish pushed word");

  a_clear_publishes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.action == ACT_CLEAR) |-> ##2 (out_data.published_flags == '0))
    else $error("stack reset did not publish zero");

endmodule

// ===== verif/testbench.sv =====
// Testbench for keyboard_mode_flag_stack: directed and random push, pop, set-top and
// clear words on both screens, each result checked against an in-bench model of the stacks.
// Depends on rtl/kmfs_pkg.sv and rtl/keyboard_mode_flag_stack.sv.
module testbench import kmfs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_WORDS = 1530;
  localparam int unsigned QUIET_TAIL = 200;

  class flag_stack_scoreboard;
    logic [FLAG_W-1:0] entries [2][KMFS_STACK_DEPTH];
    int unsigned depth [2];
    out_word_t expected_tops [$];
    int unsigned mismatches;
    int unsigned words_seen;
    int unsigned results_seen;
    int unsigned full_pushes;
    int unsigned deep_pops;
    int unsigned empty_sets;

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function int unsigned pending();
      return expected_tops.size();
    endfunction

    // updates the model stacks and queues the top the block should publish
    function void note_word(input in_word_t w);
      int unsigned d;
      int unsigned n;
      int i;
      logic [FLAG_W-1:0] t;
      out_word_t e;
      d = depth[w.screen];
      words_seen++;
      case (w.action)
        ACT_PUSH: begin
          if (d == KMFS_STACK_DEPTH) begin
            for (i = 0; i < KMFS_STACK_DEPTH - 1; i++)
              entries[w.screen][i] = entries[w.screen][i+1];
            d = KMFS_STACK_DEPTH - 1;
            full_pushes++;
          end
          entries[w.screen][d] = w.flag_word;
          d++;
        end
        ACT_POP: begin
          n = w.pop_count;
          if (n > d) begin
            n = d;
            deep_pops++;
          end
          d -= n;
        end
        ACT_SET: begin
          if (d == 0) begin
            entries[w.screen][0] = '0;
            d = 1;
            empty_sets++;
          end
          t = entries[w.screen][d-1];
          case (w.set_mode)
            MODE_REPLACE: t = w.flag_word;
            MODE_OR:      t = t | w.flag_word;
            MODE_ANDNOT:  t = t & ~w.flag_word;
            default:      ;
          endcase
          entries[w.screen][d-1] = t;
        end
        default: d = 0;
      endcase
      depth[w.screen] = d;
      e.out_screen = w.screen;
      e.published_flags = (d == 0) ? '0 : entries[w.screen][d-1];
      expected_tops.push_back(e);
    endfunction

    task check_word(input out_word_t got);
      out_word_t e;
      if (expected_tops.size() == 0) begin
        report($sformatf("unexpected result screen=%0d flags=%h",
                         got.out_screen, got.published_flags));
      end else begin
        e = expected_tops.pop_front();
        results_seen++;
        if (got.out_screen !== e.out_screen)
          report($sformatf("out_screen got %b exp %b", got.out_screen, e.out_screen));
        if (got.published_flags !== e.published_flags)
          report($sformatf("published_flags got %h exp %h (screen %0d)",
                           got.published_flags, e.published_flags, e.out_screen));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_data = '0;
  logic out_valid;
  out_word_t out_data;
  int unsigned cycles = 0;
  flag_stack_scoreboard sb = new;

  keyboard_mode_flag_stack dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("** keyboard_mode_flag_stack: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_word(out_data);
  end

  function automatic in_word_t make_word(input action_t act, input logic scr,
                                         input logic [FLAG_W-1:0] flags,
                                         input logic [COUNT_W-1:0] cnt,
                                         input set_mode_t mode);
    in_word_t w;
    w.action = act;
    w.screen = scr;
    w.flag_word = flags;
    w.pop_count = cnt;
    w.set_mode = mode;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    in_data <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic hold_off(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic in_word_t random_word(input bit grow);
    in_word_t w;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(0, 99);
    if (grow)
      w.action = (pick < 50) ? ACT_PUSH : (pick < 65) ? ACT_POP :
                 (pick < 95) ? ACT_SET : ACT_CLEAR;
    else
      w.action = (pick < 25) ? ACT_PUSH : (pick < 60) ? ACT_POP :
                 (pick < 85) ? ACT_SET : ACT_CLEAR;
    w.screen = 1'($urandom_range(0, 1));
    w.flag_word = FLAG_W'($urandom_range(0, 31));
    sel = $urandom_range(0, 9);
    if (sel < 7)
      w.pop_count = COUNT_W'($urandom_range(0, 3));
    else if (sel < 9)
      w.pop_count = COUNT_W'($urandom_range(0, KMFS_STACK_DEPTH + 1));
    else
      w.pop_count = COUNT_W'($urandom_range(0, 255));
    w.set_mode = set_mode_t'($urandom_range(0, 3));
    return w;
  endfunction

  initial begin
    int k;
    bit grow;
    bit idle_on;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_word(make_word(ACT_CLEAR, 1'b0, 5'h1F, 8'hFF, MODE_ANDNOT));
    send_word(make_word(ACT_CLEAR, 1'b1, 5'h00, 8'h00, MODE_KEEP));
    send_word(make_word(ACT_POP,   1'b0, 5'h00, 8'h00, MODE_KEEP));
    send_word(make_word(ACT_SET,   1'b0, 5'h1F, 8'h00, MODE_KEEP));
    send_word(make_word(ACT_SET,   1'b0, 5'h1F, 8'h00, MODE_REPLACE));
    send_word(make_word(ACT_SET,   1'b0, 5'h0A, 8'h00, MODE_ANDNOT));
    send_word(make_word(ACT_SET,   1'b0, 5'h0A, 8'h00, MODE_OR));
    send_word(make_word(ACT_POP,   1'b0, 5'h00, 8'h00, MODE_KEEP));
    send_word(make_word(ACT_POP,   1'b0, 5'h00, 8'hFF, MODE_KEEP));
    send_word(make_word(ACT_SET,   1'b1, 5'h15, 8'h00, MODE_OR));
    for (k = 0; k < KMFS_STACK_DEPTH + 2; k++)
      send_word(make_word(ACT_PUSH, 1'b1, (k % 2) ? 5'h1F : 5'h00 + k[4:0],
                          8'h00, MODE_KEEP));
    send_word(make_word(ACT_POP,   1'b1, 5'h00, 8'h01, MODE_KEEP));
    send_word(make_word(ACT_POP,   1'b1, 5'h00, 8'd8, MODE_KEEP));
    send_word(make_word(ACT_PUSH,  1'b0, 5'h1F, 8'hFF, MODE_ANDNOT));
    send_word(make_word(ACT_CLEAR, 1'b1, 5'h00, 8'h00, MODE_KEEP));

    grow = 1'b1;
    idle_on = 1'b1;
    for (k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 100 == 0)
        grow = 1'($urandom_range(0, 1));
      if (k % 150 == 0)
        idle_on = ($urandom_range(0, 3) != 0);
      if (k == RANDOM_WORDS / 2)
        drain();
      send_word(random_word(grow));
      if (idle_on && k < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 14));
    end

    drain();
    repeat (6) @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    $display("covered %0d words and %0d results on both screens", sb.words_seen,
             sb.results_seen);
    $display("  with %0d pushes onto a full stack, %0d clamped pops, %0d sets on empty",
             sb.full_pushes, sb.deep_pops, sb.empty_sets);
    if (sb.mismatches == 0) begin
      $display("** keyboard_mode_flag_stack: PASSED **");
    end else begin
      $display("** keyboard_mode_flag_stack: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kmfs_pkg.sv
rtl/kmfs_mem.sv
rtl/keyboard_mode_flag_stack.sv
verif/testbench.sv
